FILE: sv/reed_solomon_ec_encoder_macros.svh
// ----------------------------------------------------------------------------
// Reed-Solomon encoder assertion macros
// Shared property macros for the encoder's port checker.
// ----------------------------------------------------------------------------
`ifndef REED_SOLOMON_EC_ENCODER_MACROS_SVH
`define REED_SOLOMON_EC_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSENC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSENC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/rsenc_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon encoder package
// Types, constants and GF(256) arithmetic shared by the encoder modules.
// ----------------------------------------------------------------------------
package rsenc_pkg;

   localparam int EC_W = 5;
   localparam logic [EC_W-1:0] EC_COUNT_RESET = 5'd10;
   localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
   localparam logic [7:0] GEN_LEAD = 8'h01;

   typedef logic [7:0] gf_type;

   typedef struct packed {
      logic shift_in;
      logic clear_rem;
      logic load_out;
      logic shift_out;
      logic gen_clear;
      logic gen_step;
   } cell_ctl_type;

   function automatic gf_type gf_xtime(input gf_type x);
      gf_type r;
      r = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'h00);
      return r;
   endfunction

   function automatic gf_type gf_mul(input gf_type a, input gf_type b);
      gf_type x;
      gf_type acc;
      x = a;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

endpackage

FILE: sv/rsenc_cell.sv
// ----------------------------------------------------------------------------
// Reed-Solomon encoder cell
// One tap of the division register: a remainder byte, its generator
// coefficient and one byte of the parity output shifter.
// ----------------------------------------------------------------------------
module rsenc_cell (
   input  logic                       clock,
   input  rsenc_pkg::cell_ctl_type    ctl,
   input  rsenc_pkg::gf_type          feedback,
   input  rsenc_pkg::gf_type          root,
   input  rsenc_pkg::gf_type          rem_right,
   input  rsenc_pkg::gf_type          gen_left,
   input  rsenc_pkg::gf_type          out_right,
   output rsenc_pkg::gf_type          rem_q,
   output rsenc_pkg::gf_type          gen_q,
   output rsenc_pkg::gf_type          out_q
);

   rsenc_pkg::gf_type rem_ff, rem_in;
   rsenc_pkg::gf_type gen_ff, gen_in;
   rsenc_pkg::gf_type out_ff, out_in;
   rsenc_pkg::gf_type rem_next;

   assign rem_next = rem_right ^ rsenc_pkg::gf_mul(feedback, gen_ff);

   always_comb begin
      if (ctl.clear_rem) begin
         rem_in = '0;
      end else if (ctl.shift_in) begin
         rem_in = rem_next;
      end else begin
         rem_in = rem_ff;
      end

      if (ctl.load_out) begin
         out_in = rem_next;
      end else if (ctl.shift_out) begin
         out_in = out_right;
      end else begin
         out_in = out_ff;
      end

      if (ctl.gen_clear) begin
         gen_in = '0;
      end else if (ctl.gen_step) begin
         gen_in = gen_ff ^ rsenc_pkg::gf_mul(gen_left, root);
      end else begin
         gen_in = gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      gen_ff <= gen_in;
      out_ff <= out_in;
   end

   assign rem_q = rem_ff;
   assign gen_q = gen_ff;
   assign out_q = out_ff;

endmodule

FILE: sv/reed_solomon_ec_encoder.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder, GF(256)
// Systematic encoder for QR-style error correction blocks.
// ----------------------------------------------------------------------------
// Data codewords arrive on the req_ stream, one byte per beat, with tlast on
// the final byte of a block. Each data beat is taken by a row of MAX_PARITY
// cells that update the division remainder in parallel. After the last data
// beat the n parity bytes leave on the rsp_ stream, highest order first,
// starting in the cycle after it, one beat per cycle while rsp_tready is high,
// tlast on the final one. Data beats of the next block are accepted while
// parity is still going out; a last data beat waits until the previous block's
// parity has drained. The csr_ channel writes the parity count n. After reset
// and after every write the generator is rebuilt by the cells in ST_INIT and
// ST_DERIVE, during which req_tready is low. A write clears the remainder and
// any pending parity. When the receiver stalls, the current beat holds on rsp_.
// ----------------------------------------------------------------------------
module reed_solomon_ec_encoder #(
   parameter int MAX_PARITY = 30
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] data_byte
   input  logic                        req_tlast,   // last_data
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] parity_byte
   output logic                        rsp_tlast,   // parity_last
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rsenc_pkg::EC_W-1:0]  csr_data
);

   localparam int DEG_W = $clog2(MAX_PARITY + 1);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_DERIVE,
      ST_RUN
   } state_type;

   state_type                   state_ff, state_in;
   logic [rsenc_pkg::EC_W-1:0]  ec_ff, ec_in;
   logic [DEG_W-1:0]            step_ff, step_in;
   logic [DEG_W-1:0]            out_cnt_ff, out_cnt_in;
   rsenc_pkg::gf_type           root_ff, root_in;
   logic [DEG_W-1:0]            degree;
   logic                        in_beat, out_beat, out_free, csr_beat;
   rsenc_pkg::cell_ctl_type     ctl;
   rsenc_pkg::gf_type           feedback;
   rsenc_pkg::gf_type           rem_q [MAX_PARITY];
   rsenc_pkg::gf_type           gen_q [MAX_PARITY];
   rsenc_pkg::gf_type           out_q [MAX_PARITY];

   always_comb begin
      if (int'(ec_ff) > MAX_PARITY) begin
         degree = DEG_W'(MAX_PARITY);
      end else begin
         degree = DEG_W'(ec_ff);
      end
   end

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid & csr_ready;
   assign out_beat  = rsp_tvalid & rsp_tready;
   assign out_free  = (out_cnt_ff == '0) || ((out_cnt_ff == DEG_W'(1)) && rsp_tready);
   assign req_tready = (state_ff == ST_RUN) && (!req_tlast || out_free);
   assign in_beat   = req_tvalid & req_tready;

   assign ctl.shift_in  = in_beat;
   assign ctl.load_out  = in_beat & req_tlast;
   assign ctl.clear_rem = (state_ff == ST_INIT) | (in_beat & req_tlast);
   assign ctl.shift_out = out_beat;
   assign ctl.gen_clear = (state_ff == ST_INIT);
   assign ctl.gen_step  = (state_ff == ST_DERIVE);

   assign feedback = req_tdata ^ rem_q[0];

   for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
      rsenc_pkg::gf_type rem_right, gen_left, out_right;
      if (k == MAX_PARITY - 1) begin : g_end
         assign rem_right = '0;
         assign out_right = '0;
      end else begin : g_mid
         assign rem_right = rem_q[k+1];
         assign out_right = out_q[k+1];
      end
      if (k == 0) begin : g_first
         assign gen_left = rsenc_pkg::GEN_LEAD;
      end else begin : g_rest
         assign gen_left = gen_q[k-1];
      end
      rsenc_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .feedback  (feedback),
         .root      (root_ff),
         .rem_right (rem_right),
         .gen_left  (gen_left),
         .out_right (out_right),
         .rem_q     (rem_q[k]),
         .gen_q     (gen_q[k]),
         .out_q     (out_q[k])
      );
   end

   always_comb begin
      state_in   = state_ff;
      ec_in      = ec_ff;
      step_in    = step_ff;
      root_in    = root_ff;
      out_cnt_in = out_cnt_ff;

      if (ctl.load_out) begin
         out_cnt_in = degree;
      end else if (out_beat) begin
         out_cnt_in = out_cnt_ff - DEG_W'(1);
      end

      unique case (state_ff)
         ST_INIT: begin
            root_in    = rsenc_pkg::GEN_LEAD;
            step_in    = degree;
            out_cnt_in = '0;
            state_in   = (degree == '0) ? ST_RUN : ST_DERIVE;
         end
         ST_DERIVE: begin
            root_in  = rsenc_pkg::gf_xtime(root_ff);
            step_in  = step_ff - DEG_W'(1);
            if (step_ff == DEG_W'(1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (csr_beat) begin
         ec_in      = csr_data;
         out_cnt_in = '0;
         state_in   = ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         ec_ff      <= rsenc_pkg::EC_COUNT_RESET;
         step_ff    <= '0;
         root_ff    <= rsenc_pkg::GEN_LEAD;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ec_ff      <= ec_in;
         step_ff    <= step_in;
         root_ff    <= root_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tlast  = (out_cnt_ff == DEG_W'(1));
   assign rsp_tdata  = out_q[0];

endmodule

FILE: sv/rsenc_checker.sv
// ----------------------------------------------------------------------------
// Reed-Solomon encoder port checker
// Checks the encoder's stream and configuration behavior at its ports.
// ----------------------------------------------------------------------------
`include "reed_solomon_ec_encoder_macros.svh"

module rsenc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic req_last_beat, rsp_beat, csr_beat;

   assign req_last_beat = req_tvalid & req_tready & req_tlast;
   assign rsp_beat      = rsp_tvalid & rsp_tready;
   assign csr_beat      = csr_valid & csr_ready;

   `RSENC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready && !csr_beat, rsp_tvalid, "stalled parity beat was dropped")
   `RSENC_ASSERT_SAME(a_no_overlap, clock, reset, req_last_beat && rsp_tvalid, rsp_tready && rsp_tlast, "last data beat taken while parity still pending")
   `RSENC_ASSERT_NEXT(a_parity_run, clock, reset, rsp_beat && !rsp_tlast && !csr_beat, rsp_tvalid, "parity run ended without a last beat")
   `RSENC_ASSERT_NEXT(a_csr_hold, clock, reset, csr_beat, !req_tready && !rsp_tvalid, "input accepted while generator is rebuilt")

endmodule

bind reed_solomon_ec_encoder rsenc_checker u_rsenc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
